FILE: rtl/smvg_pkg.sv
`default_nettype none

package smvg_pkg;

   // defaults for the top level parameters
   localparam int unsigned SINE_ENTRIES_DEFAULT = 257;
   localparam int unsigned QUEUE_DEPTH_DEFAULT  = 4;

   // register map, one 32-bit register every four bytes
   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_RING_COUNT     = 2'd0;
   localparam logic [1:0] REG_SEGMENT_COUNT  = 2'd1;
   localparam logic [1:0] REG_RING_STEP      = 2'd2;
   localparam logic [1:0] REG_SEGMENT_STEP   = 2'd3;

   // register reset values
   localparam logic [7:0]  RING_COUNT_RESET    = 8'd8;
   localparam logic [7:0]  SEGMENT_COUNT_RESET = 8'd8;
   localparam logic [15:0] RING_STEP_RESET     = 16'd4096;
   localparam logic [15:0] SEGMENT_STEP_RESET  = 16'd8192;

   // a quarter turn in phase units, cos(p) = sin(p + quarter)
   localparam logic [15:0] QUARTER_TURN = 16'h4000;

   localparam real PI_REAL = 3.14159265358979323846;
   localparam real HALF_PI = 0.5 * PI_REAL;

   typedef struct packed {
      logic [7:0]  ring_count;
      logic [7:0]  segment_count;
      logic [15:0] ring_angle_step;
      logic [15:0] segment_angle_step;
   } cfg_type;

   // one classified vertex handed from the front to the back
   typedef struct packed {
      logic [15:0] ring_phase;
      logic [15:0] segment_phase;
      logic [15:0] vertex_number;
      logic [15:0] strip_index_upper;
      logic [15:0] strip_index_lower;
      logic        indices_valid;
      logic        mesh_last;
   } walk_word_type;

   // quarter-wave table entry k, round(32767*sin(k * angle_step))
   function automatic logic [14:0] sine_entry(input int unsigned k, input real angle_step);
      real a;
      int  e;
      a = 32767.0 * $sin(angle_step * real'(k));
      e = int'(a);
      if (e > 32767) begin
         e = 32767;
      end
      if (e < 0) begin
         e = 0;
      end
      return 15'(e);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/smvg_front.sv
`default_nettype none

module smvg_front
   import smvg_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cfg_type       cfg,
   input  wire logic          req_valid,
   input  wire logic          req_restart,
   output logic               req_stall,
   input  wire logic          queue_full,
   output logic               push,
   output walk_word_type      push_word
);

   logic [7:0]  ring_counter_ff, ring_counter_in;
   logic [7:0]  segment_counter_ff, segment_counter_in;
   logic [15:0] vertex_counter_ff, vertex_counter_in;
   logic [15:0] ring_phase_ff, ring_phase_in;
   logic [15:0] segment_phase_ff, segment_phase_in;

   logic [7:0]  cur_ring;
   logic [7:0]  cur_seg;
   logic [15:0] cur_vtx;
   logic [15:0] cur_rph;
   logic [15:0] cur_sph;
   logic        last_ring;
   logic        row_end;

   // accept whenever the queue has room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // walk position seen by this word, after an optional restart
   always_comb begin
      if (req_restart) begin
         cur_ring = '0;
         cur_seg  = '0;
         cur_vtx  = '0;
         cur_rph  = '0;
         cur_sph  = '0;
      end else begin
         cur_ring = ring_counter_ff;
         cur_seg  = segment_counter_ff;
         cur_vtx  = vertex_counter_ff;
         cur_rph  = ring_phase_ff;
         cur_sph  = segment_phase_ff;
      end
   end

   assign last_ring = cur_ring >= cfg.ring_count;
   assign row_end   = cur_seg >= cfg.segment_count;

   // classify the vertex and form its strip indices
   always_comb begin
      push_word.ring_phase    = cur_rph;
      push_word.segment_phase = cur_sph;
      push_word.vertex_number = cur_vtx;
      push_word.indices_valid = !last_ring;
      push_word.mesh_last     = last_ring && row_end;
      if (last_ring) begin
         push_word.strip_index_upper = '0;
         push_word.strip_index_lower = '0;
      end else begin
         push_word.strip_index_upper = cur_vtx;
         push_word.strip_index_lower = cur_vtx + {8'd0, cfg.segment_count} + 16'd1;
      end
   end

   // advance the walk
   always_comb begin
      if (row_end && last_ring) begin
         ring_counter_in    = '0;
         segment_counter_in = '0;
         vertex_counter_in  = '0;
         ring_phase_in      = '0;
         segment_phase_in   = '0;
      end else if (row_end) begin
         ring_counter_in    = cur_ring + 8'd1;
         segment_counter_in = '0;
         vertex_counter_in  = cur_vtx + 16'd1;
         ring_phase_in      = cur_rph + cfg.ring_angle_step;
         segment_phase_in   = '0;
      end else begin
         ring_counter_in    = cur_ring;
         segment_counter_in = cur_seg + 8'd1;
         vertex_counter_in  = cur_vtx + 16'd1;
         ring_phase_in      = cur_rph;
         segment_phase_in   = cur_sph + cfg.segment_angle_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_counter_ff    <= '0;
         segment_counter_ff <= '0;
         vertex_counter_ff  <= '0;
         ring_phase_ff      <= '0;
         segment_phase_ff   <= '0;
      end else if (push) begin
         ring_counter_ff    <= ring_counter_in;
         segment_counter_ff <= segment_counter_in;
         vertex_counter_ff  <= vertex_counter_in;
         ring_phase_ff      <= ring_phase_in;
         segment_phase_ff   <= segment_phase_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/smvg_queue.sv
`default_nettype none

module smvg_queue
   import smvg_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire walk_word_type push_word,
   output logic               full,
   input  wire logic          pop,
   output logic               not_empty,
   output walk_word_type      pop_word
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   walk_word_type store [DEPTH];

   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = count_ff == CW'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_word  = store[rd_ptr_ff];

   // pointer wrap and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         store[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/smvg_back.sv
`default_nettype none

module smvg_back
   import smvg_pkg::*;
#(
   parameter int unsigned SINE_TABLE_ENTRIES = SINE_ENTRIES_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          word_valid,
   input  wire walk_word_type word,
   output logic               pop,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [15:0]        rsp_pos_x,
   output logic [15:0]        rsp_pos_y,
   output logic [15:0]        rsp_pos_z,
   output logic [15:0]        rsp_vertex_number,
   output logic [15:0]        rsp_strip_index_upper,
   output logic [15:0]        rsp_strip_index_lower,
   output logic               rsp_indices_valid,
   output logic               rsp_mesh_last
);

   localparam int unsigned IDX_W = $clog2(SINE_TABLE_ENTRIES);
   localparam int unsigned PROD_W = 14 + IDX_W;
   localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(SINE_TABLE_ENTRIES - 1);
   // angle between neighboring table entries, in radians
   localparam real ENTRY_ANGLE = HALF_PI / real'(SINE_TABLE_ENTRIES - 1);

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic             negate;
   } lookup_type;

   typedef struct packed {
      logic [15:0] vertex_number;
      logic [15:0] strip_index_upper;
      logic [15:0] strip_index_lower;
      logic        indices_valid;
      logic        mesh_last;
   } tag_type;

   // quarter-wave table
   logic [14:0] sine_rom [SINE_TABLE_ENTRIES];

   for (genvar k = 0; k < SINE_TABLE_ENTRIES; k++) begin : g_rom
      localparam logic [14:0] ENTRY_VALUE = sine_entry(k, ENTRY_ANGLE);
      assign sine_rom[k] = ENTRY_VALUE;
   end

   // phase to table index, mirrored in odd quadrants
   function automatic lookup_type phase_lookup(input logic [15:0] phase);
      logic [PROD_W-1:0] prod;
      lookup_type        res;
      prod = {{IDX_W{1'b0}}, phase[13:0]} * {14'd0, LAST_ENTRY};
      res.index  = prod[PROD_W-1:14];
      res.negate = phase[15];
      if (phase[14]) begin
         res.index = LAST_ENTRY - res.index;
      end
      return res;
   endfunction

   function automatic logic signed [15:0] read_sine(input lookup_type lk);
      logic [15:0] mag;
      mag = {1'b0, sine_rom[lk.index]};
      return lk.negate ? -mag : mag;
   endfunction

   // stage 1: table indices
   logic        s1_valid_ff;
   lookup_type  s1_ring_sin_ff, s1_ring_cos_ff, s1_seg_sin_ff, s1_seg_cos_ff;
   tag_type     s1_tag_ff;

   // stage 2: sine and cosine values
   logic               s2_valid_ff;
   logic signed [15:0] s2_radius_ff, s2_y_ff, s2_seg_sin_ff, s2_seg_cos_ff;
   tag_type            s2_tag_ff;

   // stage 3: output word
   logic               s3_valid_ff;
   logic signed [15:0] s3_x_ff, s3_y_ff, s3_z_ff;
   tag_type            s3_tag_ff;

   logic               s3_ready, s2_ready, s1_ready;
   logic signed [31:0] prod_x, prod_z;

   // a stage loads when it is empty or its word moves on
   assign s3_ready = !s3_valid_ff || !rsp_stall;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;
   assign pop      = word_valid && s1_ready;

   assign prod_x = s2_radius_ff * s2_seg_sin_ff;
   assign prod_z = s2_radius_ff * s2_seg_cos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= word_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ring_sin_ff <= phase_lookup(word.ring_phase);
         s1_ring_cos_ff <= phase_lookup(word.ring_phase + QUARTER_TURN);
         s1_seg_sin_ff  <= phase_lookup(word.segment_phase);
         s1_seg_cos_ff  <= phase_lookup(word.segment_phase + QUARTER_TURN);
         s1_tag_ff.vertex_number     <= word.vertex_number;
         s1_tag_ff.strip_index_upper <= word.strip_index_upper;
         s1_tag_ff.strip_index_lower <= word.strip_index_lower;
         s1_tag_ff.indices_valid     <= word.indices_valid;
         s1_tag_ff.mesh_last         <= word.mesh_last;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_radius_ff  <= read_sine(s1_ring_sin_ff);
         s2_y_ff       <= read_sine(s1_ring_cos_ff);
         s2_seg_sin_ff <= read_sine(s1_seg_sin_ff);
         s2_seg_cos_ff <= read_sine(s1_seg_cos_ff);
         s2_tag_ff     <= s1_tag_ff;
      end
      if (s2_valid_ff && s3_ready) begin
         // floor of the product over 2^15
         s3_x_ff   <= prod_x[30:15];
         s3_z_ff   <= prod_z[30:15];
         s3_y_ff   <= s2_y_ff;
         s3_tag_ff <= s2_tag_ff;
      end
   end

   assign rsp_valid             = s3_valid_ff;
   assign rsp_pos_x             = s3_x_ff;
   assign rsp_pos_y             = s3_y_ff;
   assign rsp_pos_z             = s3_z_ff;
   assign rsp_vertex_number     = s3_tag_ff.vertex_number;
   assign rsp_strip_index_upper = s3_tag_ff.strip_index_upper;
   assign rsp_strip_index_lower = s3_tag_ff.strip_index_lower;
   assign rsp_indices_valid     = s3_tag_ff.indices_valid;
   assign rsp_mesh_last         = s3_tag_ff.mesh_last;

endmodule

`default_nettype wire

FILE: rtl/sphere_mesh_vertex_generator.sv
`default_nettype none

// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_restart
// rsp       out        rsp_valid / rsp_stall   pos_x/y/z, vertex_number, strip indices, flags
// csr       in         psel / penable / pwrite 32-bit registers at 0x0, 0x4, 0x8, 0xc
//
// one word per cycle sustained while rsp_stall is low; an accepted word passes through the queue
// and then the table index, table read and coordinate multiply registers before it reaches rsp.
// synchronous active-high reset clears the walk, the queue and the registers.
// req_stall rises only when the front-to-back queue is full; an rsp stall fills the
// back pipeline and then the queue before the request side is held.

module sphere_mesh_vertex_generator
   import smvg_pkg::*;
#(
   parameter int unsigned SINE_TABLE_ENTRIES = SINE_ENTRIES_DEFAULT,
   parameter int unsigned QUEUE_DEPTH        = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_restart,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [15:0]                rsp_pos_x,
   output logic [15:0]                rsp_pos_y,
   output logic [15:0]                rsp_pos_z,
   output logic [15:0]                rsp_vertex_number,
   output logic [15:0]                rsp_strip_index_upper,
   output logic [15:0]                rsp_strip_index_lower,
   output logic                       rsp_indices_valid,
   output logic                       rsp_mesh_last,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   cfg_type       cfg_ff;
   logic          csr_write;
   logic          queue_full;
   logic          queue_not_empty;
   logic          push;
   logic          pop;
   walk_word_type push_word;
   walk_word_type pop_word;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ring_count         <= RING_COUNT_RESET;
         cfg_ff.segment_count      <= SEGMENT_COUNT_RESET;
         cfg_ff.ring_angle_step    <= RING_STEP_RESET;
         cfg_ff.segment_angle_step <= SEGMENT_STEP_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_RING_COUNT: begin
               cfg_ff.ring_count <= csr_pwdata[7:0];
            end
            REG_SEGMENT_COUNT: begin
               cfg_ff.segment_count <= csr_pwdata[7:0];
            end
            REG_RING_STEP: begin
               cfg_ff.ring_angle_step <= csr_pwdata[15:0];
            end
            REG_SEGMENT_STEP: begin
               cfg_ff.segment_angle_step <= csr_pwdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr[3:2])
         REG_RING_COUNT:    csr_prdata = {24'd0, cfg_ff.ring_count};
         REG_SEGMENT_COUNT: csr_prdata = {24'd0, cfg_ff.segment_count};
         REG_RING_STEP:     csr_prdata = {16'd0, cfg_ff.ring_angle_step};
         REG_SEGMENT_STEP:  csr_prdata = {16'd0, cfg_ff.segment_angle_step};
         default:           csr_prdata = '0;
      endcase
   end

   // walk and classify
   smvg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_restart (req_restart),
      .req_stall   (req_stall),
      .queue_full  (queue_full),
      .push        (push),
      .push_word   (push_word)
   );

   // decoupling queue
   smvg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_not_empty),
      .pop_word  (pop_word)
   );

   // coordinates
   smvg_back #(
      .SINE_TABLE_ENTRIES (SINE_TABLE_ENTRIES)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .word_valid            (queue_not_empty),
      .word                  (pop_word),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_pos_x             (rsp_pos_x),
      .rsp_pos_y             (rsp_pos_y),
      .rsp_pos_z             (rsp_pos_z),
      .rsp_vertex_number     (rsp_vertex_number),
      .rsp_strip_index_upper (rsp_strip_index_upper),
      .rsp_strip_index_lower (rsp_strip_index_lower),
      .rsp_indices_valid     (rsp_indices_valid),
      .rsp_mesh_last         (rsp_mesh_last)
   );

endmodule

`default_nettype wire
